FILE: rtl/core/shps_pkg.sv
// Shared types, constants and tables for the ship heading and position step.
// Used by every module under rtl/core; depends on nothing.
package shps_pkg;

    localparam int SINE_TABLE_ENTRIES     = 1024;
    localparam int POSITION_FRACTION_BITS = 8;
    localparam int SINE_INDEX_BITS        = $clog2(SINE_TABLE_ENTRIES);
    localparam int POS_SHIFT              = 26 - POSITION_FRACTION_BITS;

    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [32:0] CORDIC_START = 33'sd652032875;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED_STEP = 3'd0,
        CFG_ANGLE_GAIN = 3'd1,
        CFG_LAG_GAIN   = 3'd2,
        CFG_GRID_LOW   = 3'd3,
        CFG_GRID_HIGH  = 3'd4,
        CFG_GOAL_X_MIN = 3'd5,
        CFG_GOAL_Y_MIN = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_LAG = 2'd0,
        MUL_HDG = 2'd1,
        MUL_PX  = 2'd2,
        MUL_PY  = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic               command;
        logic signed [19:0] start_x;
        logic signed [19:0] start_y;
        logic        [15:0] start_heading;
        logic signed [15:0] start_turn_rate;
        logic signed [15:0] control_rate;
    } in_beat_t;

    typedef struct packed {
        logic signed [19:0] pos_x_out;
        logic signed [19:0] pos_y_out;
        logic        [15:0] heading_out;
        logic signed [15:0] turn_rate_out;
        logic               outside_grid;
        logic               reached_goal;
    } out_beat_t;

    typedef struct packed {
        logic        [15:0] speed_step;
        logic        [15:0] angle_gain;
        logic        [15:0] lag_gain;
        logic signed [19:0] grid_low;
        logic signed [19:0] grid_high;
        logic signed [19:0] goal_x_min;
        logic signed [19:0] goal_y_min;
    } cfg_t;

    typedef struct packed {
        logic              load_item;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              upd_tr;
        logic              upd_hdg;
        logic              cord_init;
        logic              cord_step;
        logic [STEP_W-1:0] step_idx;
        logic              upd_px;
        logic              upd_py;
        logic              out_load;
    } dp_cmd_t;

    // CORDIC arc table, 2^24 units per turn
    function automatic logic [21:0] arc_units(input logic [STEP_W-1:0] i);
        logic [21:0] a;
        case (i)
            5'd0:    a = 22'd2097152;
            5'd1:    a = 22'd1238021;
            5'd2:    a = 22'd654136;
            5'd3:    a = 22'd332050;
            5'd4:    a = 22'd166669;
            5'd5:    a = 22'd83416;
            5'd6:    a = 22'd41718;
            5'd7:    a = 22'd20860;
            5'd8:    a = 22'd10430;
            5'd9:    a = 22'd5215;
            5'd10:   a = 22'd2608;
            5'd11:   a = 22'd1304;
            5'd12:   a = 22'd652;
            5'd13:   a = 22'd326;
            5'd14:   a = 22'd163;
            5'd15:   a = 22'd82;
            5'd16:   a = 22'd41;
            5'd17:   a = 22'd20;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/shps_cfg.sv
// Configuration register file for the ship step block.
// Depends on shps_pkg.
module shps_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [shps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [shps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output shps_pkg::cfg_t                      cfg
);

    shps_pkg::cfg_t cfg_reg;
    shps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (shps_pkg::cfg_index_t'(cfg_index))
                shps_pkg::CFG_SPEED_STEP: cfg_next.speed_step = cfg_data[15:0];
                shps_pkg::CFG_ANGLE_GAIN: cfg_next.angle_gain = cfg_data[15:0];
                shps_pkg::CFG_LAG_GAIN:   cfg_next.lag_gain   = cfg_data[15:0];
                shps_pkg::CFG_GRID_LOW:   cfg_next.grid_low   = $signed(cfg_data);
                shps_pkg::CFG_GRID_HIGH:  cfg_next.grid_high  = $signed(cfg_data);
                shps_pkg::CFG_GOAL_X_MIN: cfg_next.goal_x_min = $signed(cfg_data);
                shps_pkg::CFG_GOAL_Y_MIN: cfg_next.goal_y_min = $signed(cfg_data);
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_step <= 16'd2458;
            cfg_reg.angle_gain <= 16'd2086;
            cfg_reg.lag_gain   <= 16'd2621;
            cfg_reg.grid_low   <= 20'sd0;
            cfg_reg.grid_high  <= 20'sd256000;
            cfg_reg.goal_x_min <= 20'sd230400;
            cfg_reg.goal_y_min <= 20'sd230400;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/shps_ctrl.sv
// Ship step sequencer: a step item walks lag, heading, CORDIC and position
// phases, a load skips them; owns both handshakes. Depends on shps_pkg.
module shps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_command,
    output logic               out_valid,
    input  logic               out_ready,
    output shps_pkg::dp_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_LAG_MUL   = 12'b0000_0000_0010,
        S_LAG_ADD   = 12'b0000_0000_0100,
        S_HDG_MUL   = 12'b0000_0000_1000,
        S_HDG_ADD   = 12'b0000_0001_0000,
        S_CORD_INIT = 12'b0000_0010_0000,
        S_CORD_ITER = 12'b0000_0100_0000,
        S_PX_MUL    = 12'b0000_1000_0000,
        S_PX_ADD    = 12'b0001_0000_0000,
        S_PY_MUL    = 12'b0010_0000_0000,
        S_PY_ADD    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [shps_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_sel = shps_pkg::MUL_LAG;
        cmd.step_idx = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = in_command ? S_LAG_MUL : S_DONE;
                end
            end
            S_LAG_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = shps_pkg::MUL_LAG;
                state_next  = S_LAG_ADD;
            end
            S_LAG_ADD:
            begin
                cmd.upd_tr = 1'b1;
                state_next = S_HDG_MUL;
            end
            S_HDG_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = shps_pkg::MUL_HDG;
                state_next  = S_HDG_ADD;
            end
            S_HDG_ADD:
            begin
                cmd.upd_hdg = 1'b1;
                state_next  = S_CORD_INIT;
            end
            S_CORD_INIT:
            begin
                cmd.cord_init = 1'b1;
                step_next     = '0;
                state_next    = S_CORD_ITER;
            end
            S_CORD_ITER:
            begin
                cmd.cord_step = 1'b1;
                if (step_reg == shps_pkg::STEP_W'(shps_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_PX_MUL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PX_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = shps_pkg::MUL_PX;
                state_next  = S_PX_ADD;
            end
            S_PX_ADD:
            begin
                cmd.upd_px = 1'b1;
                state_next = S_PY_MUL;
            end
            S_PY_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = shps_pkg::MUL_PY;
                state_next  = S_PY_ADD;
            end
            S_PY_ADD:
            begin
                cmd.upd_py = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/shps_dp.sv
// Datapath of the ship step: state registers, one shared multiplier,
// iterative CORDIC and the output beat register. Depends on shps_pkg.
module shps_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  shps_pkg::dp_cmd_t   cmd,
    input  shps_pkg::cfg_t      cfg,
    input  shps_pkg::in_beat_t  in_beat,
    output shps_pkg::out_beat_t out_beat
);

    localparam int IB = shps_pkg::SINE_INDEX_BITS;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7FFF;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [35:0] v);
        logic signed [19:0] r;
        if (v > 36'sd524287)
            r = 20'sh7FFFF;
        else if (v < -36'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

    logic signed [19:0] px_reg, px_next;
    logic signed [19:0] py_reg, py_next;
    logic        [15:0] hdg_reg, hdg_next;
    logic signed [15:0] tr_reg, tr_next;
    logic signed [15:0] rate_cmd_reg;
    logic signed [34:0] prod_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic               flip_reg;
    shps_pkg::out_beat_t out_reg;

    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] prod_next;
    logic signed [17:0] sin_q, cos_q;
    logic signed [19:0] tr_sum;
    logic        [15:0] qang;
    logic signed [16:0] ang_s, ang_f;
    logic               flip_n;
    logic signed [32:0] shx, shy;
    logic signed [24:0] arc;
    logic signed [34:0] pdelta;
    logic signed [16:0] ty, tx;

    assign ty    = cy_reg[32:16];
    assign tx    = cx_reg[32:16];
    assign sin_q = flip_reg ? -{ty[16], ty} : {ty[16], ty};
    assign cos_q = flip_reg ? -{tx[16], tx} : {tx[16], tx};

    always_comb
    begin
        case (cmd.mul_sel)
            shps_pkg::MUL_LAG:
            begin
                mul_a = {{2{rate_cmd_reg[15]}}, rate_cmd_reg} - {{2{tr_reg[15]}}, tr_reg};
                mul_b = $signed({1'b0, cfg.lag_gain});
            end
            shps_pkg::MUL_HDG:
            begin
                mul_a = {{2{tr_reg[15]}}, tr_reg};
                mul_b = $signed({1'b0, cfg.angle_gain});
            end
            shps_pkg::MUL_PX:
            begin
                mul_a = sin_q;
                mul_b = $signed({1'b0, cfg.speed_step});
            end
            shps_pkg::MUL_PY:
            begin
                mul_a = cos_q;
                mul_b = $signed({1'b0, cfg.speed_step});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign tr_sum = {{4{tr_reg[15]}}, tr_reg} + {prod_reg[34], prod_reg[34:16]};

    // heading quantised to the sine table grid
    assign qang  = {hdg_reg[15:16-IB], {(16-IB){1'b0}}};
    always_comb
    begin
        ang_s  = $signed({qang[15], qang});
        flip_n = 1'b0;
        ang_f  = ang_s;
        if (ang_s > 17'sd16384)
        begin
            ang_f  = ang_s - 17'sd32768;
            flip_n = 1'b1;
        end
        else if (ang_s < -17'sd16384)
        begin
            ang_f  = ang_s + 17'sd32768;
            flip_n = 1'b1;
        end
    end

    assign shx    = cx_reg >>> cmd.step_idx;
    assign shy    = cy_reg >>> cmd.step_idx;
    assign arc    = $signed({3'b000, shps_pkg::arc_units(cmd.step_idx)});
    assign pdelta = prod_reg >>> shps_pkg::POS_SHIFT;

    always_comb
    begin
        px_next  = px_reg;
        py_next  = py_reg;
        hdg_next = hdg_reg;
        tr_next  = tr_reg;
        if (cmd.load_item && !in_beat.command)
        begin
            px_next  = in_beat.start_x;
            py_next  = in_beat.start_y;
            hdg_next = in_beat.start_heading;
            tr_next  = in_beat.start_turn_rate;
        end
        if (cmd.upd_tr)
            tr_next = sat16(tr_sum);
        if (cmd.upd_hdg)
            hdg_next = hdg_reg + prod_reg[25:10];
        if (cmd.upd_px)
            px_next = sat20({{16{px_reg[19]}}, px_reg} + {pdelta[34], pdelta});
        if (cmd.upd_py)
            py_next = sat20({{16{py_reg[19]}}, py_reg} + {pdelta[34], pdelta});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg  <= '0;
            py_reg  <= '0;
            hdg_reg <= '0;
            tr_reg  <= '0;
        end
        else
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            hdg_reg <= hdg_next;
            tr_reg  <= tr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item && in_beat.command)
            rate_cmd_reg <= in_beat.control_rate;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.cord_init)
        begin
            cx_reg   <= shps_pkg::CORDIC_START;
            cy_reg   <= '0;
            cz_reg   <= {ang_f, 8'b0};
            flip_reg <= flip_n;
        end
        else if (cmd.cord_step)
        begin
            if (!cz_reg[24])
            begin
                cx_reg <= cx_reg - shy;
                cy_reg <= cy_reg + shx;
                cz_reg <= cz_reg - arc;
            end
            else
            begin
                cx_reg <= cx_reg + shy;
                cy_reg <= cy_reg - shx;
                cz_reg <= cz_reg + arc;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.pos_x_out     <= px_reg;
            out_reg.pos_y_out     <= py_reg;
            out_reg.heading_out   <= hdg_reg;
            out_reg.turn_rate_out <= tr_reg;
            out_reg.outside_grid  <= (px_reg < cfg.grid_low) || (px_reg > cfg.grid_high) ||
                                     (py_reg < cfg.grid_low) || (py_reg > cfg.grid_high);
            out_reg.reached_goal  <= (px_reg >= cfg.goal_x_min) && (py_reg >= cfg.goal_y_min);
        end
    end

    assign out_beat = out_reg;

endmodule

FILE: rtl/core/ship_heading_position_step.sv
// Top level of the ship heading and position step block.
// Depends on shps_pkg, shps_cfg, shps_ctrl and shps_dp.
//
// Each input beat either loads position, heading and turn rate (command 0)
// or advances a first-order steering model by one time step (command 1),
// and yields one output beat with the new state and the grid and goal
// flags. A load goes straight to the result register. A step uses the shared
// multiplier and an add state for the rate lag and then the heading update,
// a setup state and 18 iterations of the sine/cosine CORDIC unit, then the
// multiplier and an add state for the x and y moves, and a state to register
// the result. One item is worked on at a time; the next is accepted once the
// current result sits in the output register, even if that beat has not yet
// been taken. Configuration writes are accepted every cycle but should be
// issued only while the block is idle.
module ship_heading_position_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  shps_pkg::in_beat_t                in_beat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output shps_pkg::out_beat_t               out_beat,
    input  logic                              cfg_we,
    input  logic [shps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [shps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    shps_pkg::cfg_t    cfg;
    shps_pkg::dp_cmd_t cmd;

    shps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_command (in_beat.command),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    shps_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_beat  (in_beat),
        .out_beat (out_beat)
    );

endmodule

FILE: verif/ship_heading_position_step_test.sv
// Self-checking testbench for ship_heading_position_step: directed and random
// load/step beats checked against an in-bench fixed-point steering predictor.
// Depends on shps_pkg and the ship_heading_position_step RTL.
module ship_heading_position_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    localparam logic [shps_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    localparam longint POS_MIN = -524288;
    localparam longint POS_MAX = 524287;
    localparam longint RATE_MIN = -32768;
    localparam longint RATE_MAX = 32767;
    localparam longint TURN_MASK = 65535;
    localparam longint CORDIC_X0 = 652032875;
    localparam int TRIG_ITERS = 18;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 120;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES = 30;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 65;

    typedef struct packed {
        shps_pkg::in_beat_t  beat;
        logic                typed;
        shps_pkg::out_beat_t result;
    } trial_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    shps_pkg::in_beat_t                   in_beat;
    logic                                 out_valid;
    logic                                 out_ready;
    shps_pkg::out_beat_t                  out_beat;
    logic                                 cfg_we;
    logic [shps_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [shps_pkg::CFG_DATA_W-1:0]      cfg_data;

    longint arc_steps [0:17] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 82, 41, 20
    };

    longint cfg_speed, cfg_angle_gain, cfg_lag_gain;
    longint cfg_grid_low, cfg_grid_high, cfg_goal_x, cfg_goal_y;
    longint ship_x, ship_y, ship_heading, ship_rate;

    shps_pkg::out_beat_t predicted_states[$];
    int mismatches = 0;
    int beats_checked = 0;
    int loads_sent = 0;
    int steps_sent = 0;
    int settings_used = 0;
    int goal_seen = 0;
    int off_grid_seen = 0;
    int burst_left = 0;

    ship_heading_position_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint limit_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q1.14 sine and cosine of a binary angle, CORDIC in Q30
    function automatic void sin_cos_of(input logic [15:0] angle, output longint sn,
                                       output longint cs);
        longint s, x, y, z, nx;
        bit flip;
        int i;
        s = longint'($signed(angle));
        flip = 1'b0;
        if (s > 16384)
        begin
            s = s - 32768;
            flip = 1'b1;
        end
        else if (s < -16384)
        begin
            s = s + 32768;
            flip = 1'b1;
        end
        x = CORDIC_X0;
        y = 0;
        z = s * 256;
        for (i = 0; i < TRIG_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arc_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arc_steps[i];
            end
            x = nx;
        end
        x = x >>> 16;
        y = y >>> 16;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic shps_pkg::out_beat_t next_ship_state(input shps_pkg::in_beat_t b);
        shps_pkg::out_beat_t r;
        longint d, idx, qang, sn, cs;
        if (b.command == CMD_LOAD)
        begin
            ship_x = longint'($signed(b.start_x));
            ship_y = longint'($signed(b.start_y));
            ship_heading = longint'(b.start_heading);
            ship_rate = longint'($signed(b.start_turn_rate));
        end
        else
        begin
            d = ((longint'($signed(b.control_rate)) - ship_rate) * cfg_lag_gain) >>> 16;
            ship_rate = limit_to(ship_rate + d, RATE_MIN, RATE_MAX);
            d = (ship_rate * cfg_angle_gain) >>> 10;
            ship_heading = (ship_heading + d) & TURN_MASK;
            idx = (ship_heading * shps_pkg::SINE_TABLE_ENTRIES) >>> 16;
            qang = ((idx <<< 16) / shps_pkg::SINE_TABLE_ENTRIES) & TURN_MASK;
            sin_cos_of(qang[15:0], sn, cs);
            ship_x = limit_to(ship_x + ((cfg_speed * sn) >>> shps_pkg::POS_SHIFT),
                              POS_MIN, POS_MAX);
            ship_y = limit_to(ship_y + ((cfg_speed * cs) >>> shps_pkg::POS_SHIFT),
                              POS_MIN, POS_MAX);
        end
        r.pos_x_out = ship_x[19:0];
        r.pos_y_out = ship_y[19:0];
        r.heading_out = ship_heading[15:0];
        r.turn_rate_out = ship_rate[15:0];
        r.outside_grid = (ship_x < cfg_grid_low || ship_x > cfg_grid_high ||
                          ship_y < cfg_grid_low || ship_y > cfg_grid_high);
        r.reached_goal = (ship_x >= cfg_goal_x && ship_y >= cfg_goal_y);
        return r;
    endfunction

    function automatic void reset_model();
        cfg_speed = 2458;
        cfg_angle_gain = 2086;
        cfg_lag_gain = 2621;
        cfg_grid_low = 0;
        cfg_grid_high = 256000;
        cfg_goal_x = 230400;
        cfg_goal_y = 230400;
        ship_x = 0;
        ship_y = 0;
        ship_heading = 0;
        ship_rate = 0;
    endfunction

    function automatic shps_pkg::in_beat_t load_beat(input logic [19:0] x,
                                                     input logic [19:0] y,
                                                     input logic [15:0] hdg,
                                                     input logic [15:0] rate);
        shps_pkg::in_beat_t b;
        b.command = CMD_LOAD;
        b.start_x = x;
        b.start_y = y;
        b.start_heading = hdg;
        b.start_turn_rate = rate;
        b.control_rate = 16'($urandom());
        return b;
    endfunction

    function automatic shps_pkg::in_beat_t step_beat(input logic [15:0] rate);
        shps_pkg::in_beat_t b;
        b.command = CMD_STEP;
        b.start_x = 20'($urandom());
        b.start_y = 20'($urandom());
        b.start_heading = 16'($urandom());
        b.start_turn_rate = 16'($urandom());
        b.control_rate = rate;
        return b;
    endfunction

    function automatic shps_pkg::out_beat_t state_beat(input logic [19:0] x,
                                                       input logic [19:0] y,
                                                       input logic [15:0] hdg,
                                                       input logic [15:0] rate,
                                                       input logic off_grid,
                                                       input logic goal);
        shps_pkg::out_beat_t r;
        r.pos_x_out = x;
        r.pos_y_out = y;
        r.heading_out = hdg;
        r.turn_rate_out = rate;
        r.outside_grid = off_grid;
        r.reached_goal = goal;
        return r;
    endfunction

    function automatic trial_t row(input shps_pkg::in_beat_t b, input logic typed,
                                   input shps_pkg::out_beat_t r);
        trial_t t;
        t.beat = b;
        t.typed = typed;
        t.result = r;
        return t;
    endfunction

    function automatic logic [15:0] random_rate();
        if ($urandom_range(0, 1) == 1)
            return 16'($urandom());
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    function automatic logic [19:0] random_coordinate();
        longint spot;
        case ($urandom_range(0, 5))
            0: spot = cfg_grid_low;
            1: spot = cfg_grid_high;
            2: spot = cfg_goal_x;
            3: spot = cfg_goal_y;
            4: spot = 0;
            default: spot = longint'($signed(20'($urandom())));
        endcase
        spot = limit_to(spot + longint'($urandom_range(0, 8192)) - 4096, POS_MIN, POS_MAX);
        return spot[19:0];
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input shps_pkg::in_beat_t b, input logic typed,
                             input shps_pkg::out_beat_t typed_out);
        shps_pkg::out_beat_t predicted;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        predicted = next_ship_state(b);
        predicted_states = {predicted_states, typed ? typed_out : predicted};
        if (b.command == CMD_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    task automatic write_reg(input logic [shps_pkg::CFG_INDEX_W-1:0] index,
                             input logic [shps_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            shps_pkg::CFG_SPEED_STEP: cfg_speed = longint'(value[15:0]);
            shps_pkg::CFG_ANGLE_GAIN: cfg_angle_gain = longint'(value[15:0]);
            shps_pkg::CFG_LAG_GAIN:   cfg_lag_gain = longint'(value[15:0]);
            shps_pkg::CFG_GRID_LOW:   cfg_grid_low = longint'($signed(value));
            shps_pkg::CFG_GRID_HIGH:  cfg_grid_high = longint'($signed(value));
            shps_pkg::CFG_GOAL_X_MIN: cfg_goal_x = longint'($signed(value));
            shps_pkg::CFG_GOAL_Y_MIN: cfg_goal_y = longint'($signed(value));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] speed, input logic [15:0] angle,
                                input logic [15:0] lag, input logic [19:0] lo,
                                input logic [19:0] hi, input logic [19:0] gx,
                                input logic [19:0] gy);
        write_reg(shps_pkg::CFG_SPEED_STEP, {4'h0, speed});
        write_reg(shps_pkg::CFG_ANGLE_GAIN, {4'h0, angle});
        write_reg(shps_pkg::CFG_LAG_GAIN, {4'h0, lag});
        write_reg(shps_pkg::CFG_GRID_LOW, lo);
        write_reg(shps_pkg::CFG_GRID_HIGH, hi);
        write_reg(shps_pkg::CFG_GOAL_X_MIN, gx);
        write_reg(shps_pkg::CFG_GOAL_Y_MIN, gy);
        write_reg(REG_SPARE, 20'($urandom()));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic set_phase_regs(input int phase);
        case (phase)
            0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'h80000, 20'h7FFFF,
                            20'h7FFFF, 20'h7FFFF);
            1: program_regs(16'h0000, 16'h0000, 16'h0000, 20'h00000, 20'h00000,
                            20'h80000, 20'h80000);
            2: program_regs(16'($urandom()), 16'($urandom_range(0, 6000)), 16'($urandom()),
                            20'(-int'($urandom_range(0, 100000))),
                            20'($urandom_range(0, 300000)), 20'($urandom_range(0, 300000)),
                            20'($urandom_range(0, 300000)));
            // inverted grid
            3: program_regs(16'hFFFF, 16'($urandom()), 16'($urandom()),
                            20'($urandom_range(100000, 300000)),
                            20'(-int'($urandom_range(0, 100000))),
                            20'($urandom()), 20'($urandom()));
            4: program_regs(16'd2458, 16'd2086, 16'd2621, 20'(-2000), 20'd2000,
                            20'd0, 20'd0);
            default: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  20'($urandom()), 20'($urandom()),
                                  20'($urandom()), 20'($urandom()));
        endcase
    endtask

    task automatic run_voyages(input int count);
        shps_pkg::in_beat_t b;
        int sent, legs, k;
        sent = 0;
        while (sent < count)
        begin
            b = load_beat(random_coordinate(), random_coordinate(), 16'($urandom()),
                          random_rate());
            send_item(b, 1'b0, '0);
            sent++;
            if ($urandom_range(0, 7) != 0)
            begin
                legs = $urandom_range(1, 20);
                for (k = 0; k < legs; k++)
                begin
                    send_item(step_beat(random_rate()), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        while (predicted_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        shps_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_states.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat expected none, got %h", $time, out_beat);
            end
            else
            begin
                want = predicted_states.pop_front();
                compare_field("pos_x_out", $signed(want.pos_x_out), $signed(out_beat.pos_x_out));
                compare_field("pos_y_out", $signed(want.pos_y_out), $signed(out_beat.pos_y_out));
                compare_field("heading_out", want.heading_out, out_beat.heading_out);
                compare_field("turn_rate_out", $signed(want.turn_rate_out),
                              $signed(out_beat.turn_rate_out));
                compare_field("outside_grid", want.outside_grid, out_beat.outside_grid);
                compare_field("reached_goal", want.reached_goal, out_beat.reached_goal);
            end
            beats_checked++;
            if (out_beat.reached_goal)
                goal_seen++;
            if (out_beat.outside_grid)
                off_grid_seen++;
        end
    end

    initial
    begin : receiver
        int mode, span, tick, hold;
        bit held;
        mode = 0;
        span = 0;
        tick = 0;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            // long stall so the block backs up into its input
            if (!held && beats_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
            end
            span--;
            tick++;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ((tick % 7) >= 3);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        trial_t trials[$];
        int i, phase;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_beat <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        trials = {trials, row(load_beat(20'h7FFFF, 20'h7FFFF, 16'h0000, 16'h0000), 1'b1,
                  state_beat(20'h7FFFF, 20'h7FFFF, 16'h0000, 16'h0000, 1'b1, 1'b1))};
        trials = {trials, row(load_beat(20'h80000, 20'h80000, 16'hFFFF, 16'h7FFF), 1'b1,
                  state_beat(20'h80000, 20'h80000, 16'hFFFF, 16'h7FFF, 1'b1, 1'b0))};
        trials = {trials, row(step_beat(16'h7FFF), 1'b0, '0)};
        trials = {trials, row(step_beat(16'h8000), 1'b0, '0)};
        trials = {trials, row(load_beat(20'd0, 20'd0, 16'h0000, 16'h8000), 1'b1,
                  state_beat(20'd0, 20'd0, 16'h0000, 16'h8000, 1'b0, 1'b0))};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        trials = {trials, row(step_beat(16'h7FFF), 1'b0, '0)};
        trials = {trials, row(load_beat(20'd256000, 20'd230400, 16'h4000, 16'h0000), 1'b1,
                  state_beat(20'd256000, 20'd230400, 16'h4000, 16'h0000, 1'b0, 1'b1))};
        trials = {trials, row(load_beat(20'd256001, 20'd230399, 16'h8000, 16'h0000), 1'b1,
                  state_beat(20'd256001, 20'd230399, 16'h8000, 16'h0000, 1'b1, 1'b0))};
        // drive east and south into the position limits
        trials = {trials, row(load_beat(20'd524200, 20'd100, 16'h4000, 16'h0000), 1'b1,
                  state_beat(20'd524200, 20'd100, 16'h4000, 16'h0000, 1'b1, 1'b0))};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        trials = {trials, row(load_beat(20'd100, 20'(-524200), 16'h8000, 16'h0000), 1'b1,
                  state_beat(20'd100, 20'(-524200), 16'h8000, 16'h0000, 1'b1, 1'b0))};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        // heading wraps both ways
        trials = {trials, row(load_beat(20'd0, 20'd0, 16'hFFF0, 16'h7FFF), 1'b1,
                  state_beat(20'd0, 20'd0, 16'hFFF0, 16'h7FFF, 1'b0, 1'b0))};
        trials = {trials, row(step_beat(16'h7FFF), 1'b0, '0)};
        trials = {trials, row(load_beat(20'd0, 20'd0, 16'h0010, 16'h8000), 1'b1,
                  state_beat(20'd0, 20'd0, 16'h0010, 16'h8000, 1'b0, 1'b0))};
        trials = {trials, row(step_beat(16'h8000), 1'b0, '0)};
        trials = {trials, row(load_beat(20'd0, 20'd0, 16'hC000, 16'h0000), 1'b1,
                  state_beat(20'd0, 20'd0, 16'hC000, 16'h0000, 1'b0, 1'b0))};
        trials = {trials, row(step_beat(16'h0000), 1'b0, '0)};
        trials = {trials, row(load_beat(20'h55555, 20'hAAAAA, 16'h5555, 16'hAAAA), 1'b1,
                  state_beat(20'h55555, 20'hAAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0))};
        trials = {trials, row(step_beat(16'hAAAA), 1'b0, '0)};
        trials = {trials, row(step_beat(16'h5555), 1'b0, '0)};

        for (i = 0; i < trials.size(); i++)
            send_item(trials[i].beat, trials[i].typed, trials[i].result);
        finish_phase();

        for (phase = 0; phase < PHASES; phase++)
        begin
            set_phase_regs(phase);
            run_voyages(ITEMS_PER_PHASE);
            finish_phase();
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result beats from %0d loads and %0d steps over %0d register sets,",
                 beats_checked, loads_sent, steps_sent, settings_used + 1);
        $display("%0d beats off the grid, %0d at the goal, one long output stall.",
                 off_grid_seen, goal_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: ship_heading_position_step.f
rtl/core/shps_pkg.sv
rtl/core/shps_cfg.sv
rtl/core/shps_ctrl.sv
rtl/core/shps_dp.sv
rtl/core/ship_heading_position_step.sv
verif/ship_heading_position_step_test.sv
